// ===== sv/bcd_binary_add_sub_alu_assert.svh =====
// Assertion macros for the BCD and binary add and subtract ALU.
`ifndef BCD_BINARY_ADD_SUB_ALU_ASSERT_SVH
`define BCD_BINARY_ADD_SUB_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define BCDAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BCDAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BCDAS_ASSERT_NOW(lbl, ante, cons, msg)
`define BCDAS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bcdas_pkg.sv =====
// Types and constants shared by the BCD and binary add and subtract ALU.
package bcdas_pkg;

	localparam logic CMD_ADC = 1'b0;
	localparam logic CMD_SBC = 1'b1;

	localparam logic [4:0] LO_LIMIT   = 5'd10;
	localparam logic [3:0] LO_ADD_FIX = 4'd6;
	localparam logic [3:0] LO_SUB_FIX = 4'd10;
	localparam logic [9:0] HI_LIMIT   = 10'h0A0;
	localparam logic [9:0] HI_FIX     = 10'h060;

	typedef struct packed {
		logic       command;
		logic [7:0] accumulator;
		logic [7:0] operand;
		logic       carry_in;
		logic       decimal_in;
	} op_t;

	typedef struct packed {
		logic [7:0] result;
		logic       carry_out;
		logic       overflow_out;
	} res_t;

	typedef struct packed {
		logic advance;
		logic in_valid;
		logic dec_enable;
	} pipe_ctrl_t;

	typedef struct packed {
		logic valid_s1;
		logic valid_s2;
		logic valid_s3;
	} pipe_stat_t;

endpackage

// ===== sv/bcdas_cfg_if.sv =====
// Configuration write channel carrying the decimal enable bit.
interface bcdas_cfg_if;
	logic valid;
	logic ready;
	logic decimal_enable;

	modport source (output valid, output decimal_enable, input ready);
	modport sink (input valid, input decimal_enable, output ready);
endinterface

// ===== sv/bcdas_op_if.sv =====
// Operation request channel.
interface bcdas_op_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] accumulator;
	logic [7:0] operand;
	logic       carry_in;
	logic       decimal_in;

	modport source (output valid, output command, output accumulator, output operand,
		output carry_in, output decimal_in, input ready);
	modport sink (input valid, input command, input accumulator, input operand,
		input carry_in, input decimal_in, output ready);
endinterface

// ===== sv/bcdas_res_if.sv =====
// Result channel.
interface bcdas_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       carry_out;
	logic       overflow_out;

	modport source (output valid, output result, output carry_out, output overflow_out,
		input ready);
	modport sink (input valid, input result, input carry_out, input overflow_out,
		output ready);
endinterface

// ===== sv/bcdas_core.sv =====
// Three stage datapath: low digit, high digit sum, decimal high correction.
module bcdas_core import bcdas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pipe_ctrl_t ctrl,
	input  op_t        op,
	output pipe_stat_t stat,
	output res_t       res
);

	logic       valid_s1, valid_s2, valid_s3;

	logic       sub_s1, dec_s1;
	logic [3:0] a_hi_s1, m_hi_s1;
	logic [5:0] lo_s1;
	logic [7:0] bin_res_s1;
	logic       bin_c_s1, bin_v_s1;

	logic       sub_s2, dec_s2;
	logic [9:0] dsum_s2;
	logic       dov_s2;
	logic [7:0] bin_res_s2;
	logic       bin_c_s2, bin_v_s2;

	res_t       res_s3;

	logic [7:0] mx;
	logic [8:0] bsum;
	logic [4:0] lo_add;
	logic [5:0] lo_sub;
	logic [5:0] lo_next;

	logic [9:0] a_hi_w, m_hi_w, a_hi_sx, m_hi_sx, lo_sx, dsum_next, t_add;
	logic       dov_next;

	logic [9:0] fix;
	logic       dec_add;

	always_comb begin
		mx = (op.command == CMD_SBC) ? ~op.operand : op.operand;
		bsum = {1'b0, op.accumulator} + {1'b0, mx} + {8'b0, op.carry_in};
		lo_add = {1'b0, op.accumulator[3:0]} + {1'b0, op.operand[3:0]} + {4'b0, op.carry_in};
		lo_sub = {2'b0, op.accumulator[3:0]} - {2'b0, op.operand[3:0]} - {5'b0, ~op.carry_in};
		if (op.command == CMD_SBC) begin
			if (lo_sub[5]) begin
				lo_next = {2'b11, lo_sub[3:0] + LO_SUB_FIX};
			end else begin
				lo_next = lo_sub;
			end
		end else begin
			if (lo_add >= LO_LIMIT) begin
				lo_next = {2'b01, lo_add[3:0] + LO_ADD_FIX};
			end else begin
				lo_next = {1'b0, lo_add};
			end
		end
	end

	always_comb begin
		a_hi_w  = {2'b00, a_hi_s1, 4'b0000};
		m_hi_w  = {2'b00, m_hi_s1, 4'b0000};
		a_hi_sx = {{2{a_hi_s1[3]}}, a_hi_s1, 4'b0000};
		m_hi_sx = {{2{m_hi_s1[3]}}, m_hi_s1, 4'b0000};
		lo_sx   = {{4{lo_s1[5]}}, lo_s1};
		if (sub_s1 == CMD_SBC) begin
			dsum_next = a_hi_w - m_hi_w + lo_sx;
		end else begin
			dsum_next = a_hi_w + m_hi_w + lo_sx;
		end
		t_add = a_hi_sx + m_hi_sx + lo_sx;
		dov_next = !((t_add[9] == t_add[8]) && (t_add[8] == t_add[7]));
	end

	always_comb begin
		dec_add = dec_s2 && (sub_s2 == CMD_ADC);
		if (sub_s2 == CMD_SBC) begin
			fix = dsum_s2[9] ? (dsum_s2 - HI_FIX) : dsum_s2;
		end else begin
			fix = (dsum_s2 >= HI_LIMIT) ? (dsum_s2 + HI_FIX) : dsum_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ctrl.advance) begin
			valid_s1 <= ctrl.in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			sub_s1     <= op.command;
			dec_s1     <= op.decimal_in && ctrl.dec_enable;
			a_hi_s1    <= op.accumulator[7:4];
			m_hi_s1    <= op.operand[7:4];
			lo_s1      <= lo_next;
			bin_res_s1 <= bsum[7:0];
			bin_c_s1   <= bsum[8];
			bin_v_s1   <= ~(op.accumulator[7] ^ mx[7]) & (op.accumulator[7] ^ bsum[7]);

			sub_s2     <= sub_s1;
			dec_s2     <= dec_s1;
			dsum_s2    <= dsum_next;
			dov_s2     <= dov_next;
			bin_res_s2 <= bin_res_s1;
			bin_c_s2   <= bin_c_s1;
			bin_v_s2   <= bin_v_s1;

			res_s3.result       <= dec_s2 ? fix[7:0] : bin_res_s2;
			res_s3.carry_out    <= dec_add ? (|fix[9:8]) : bin_c_s2;
			res_s3.overflow_out <= dec_add ? dov_s2 : bin_v_s2;
		end
	end

	assign stat.valid_s1 = valid_s1;
	assign stat.valid_s2 = valid_s2;
	assign stat.valid_s3 = valid_s3;
	assign res = res_s3;

endmodule

// ===== sv/bcd_binary_add_sub_alu.sv =====
// Top level of the BCD and binary add and subtract ALU.
//
//  channel  role   contents
//  cfg      sink   decimal_enable write, always ready
//  op       sink   command, accumulator, operand, carry_in, decimal_in
//  res      source result, carry_out, overflow_out
//
// Each request passes through the low digit, high digit and correction stages.
// One request enters every cycle and one result leaves every cycle while res is ready.
// When a result waits unaccepted the whole pipeline holds and op.ready drops.
// Reset empties the pipeline and sets decimal_enable to one.
module bcd_binary_add_sub_alu import bcdas_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bcdas_cfg_if.sink    cfg,
	bcdas_op_if.sink     op,
	bcdas_res_if.source  res
);

`include "bcd_binary_add_sub_alu_assert.svh"

	logic       decimal_enable_q;
	pipe_ctrl_t ctrl;
	pipe_stat_t stat;
	op_t        op_data;
	res_t       res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimal_enable_q <= 1'b1;
		end else if (cfg.valid) begin
			decimal_enable_q <= cfg.decimal_enable;
		end
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		ctrl.advance    = !(stat.valid_s3 && !res.ready);
		ctrl.in_valid   = op.valid;
		ctrl.dec_enable = decimal_enable_q;
		op_data.command     = op.command;
		op_data.accumulator = op.accumulator;
		op_data.operand     = op.operand;
		op_data.carry_in    = op.carry_in;
		op_data.decimal_in  = op.decimal_in;
	end

	bcdas_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.op     (op_data),
		.stat   (stat),
		.res    (res_data)
	);

	assign op.ready         = ctrl.advance;
	assign res.valid        = stat.valid_s3;
	assign res.result       = res_data.result;
	assign res.carry_out    = res_data.carry_out;
	assign res.overflow_out = res_data.overflow_out;

	`BCDAS_ASSERT_NOW(a_stall_only_on_blocked_result, !op.ready, res.valid && !res.ready, "op stalled without a blocked result")
	`BCDAS_ASSERT_NEXT(a_accept_fills_s1, op.valid && op.ready, stat.valid_s1, "accepted request missing from stage one")
	`BCDAS_ASSERT_NEXT(a_cfg_written, cfg.valid, decimal_enable_q == $past(cfg.decimal_enable), "decimal enable write lost")

endmodule
